FILE: src/rrfp_pkg.sv
// Types and constants shared by the radar report frame parser modules.
`default_nettype none

package rrfp_pkg;

   localparam int unsigned POS_W        = 6;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned RANGE_W      = 16;
   localparam int unsigned REQ_TDATA_W  = 8;
   localparam int unsigned RSP_FIELDS_W = 3 + 3 * RANGE_W;
   localparam int unsigned RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [BYTE_W-1:0] SYNC_0 = 8'hF4;
   localparam logic [BYTE_W-1:0] SYNC_1 = 8'hF3;
   localparam logic [BYTE_W-1:0] SYNC_2 = 8'hF2;
   localparam logic [BYTE_W-1:0] SYNC_3 = 8'hF1;

   localparam logic [POS_W-1:0] POS_AFTER_SYNC = 6'd4;
   localparam logic [POS_W-1:0] OFS_STATE      = 6'd8;
   localparam logic [POS_W-1:0] OFS_MOVING_LO  = 6'd9;
   localparam logic [POS_W-1:0] OFS_MOVING_HI  = 6'd10;
   localparam logic [POS_W-1:0] OFS_STILL_LO   = 6'd12;
   localparam logic [POS_W-1:0] OFS_STILL_HI   = 6'd13;

   localparam logic [BYTE_W-1:0] TGT_MOVING = 8'h01;
   localparam logic [BYTE_W-1:0] TGT_STILL  = 8'h02;
   localparam logic [BYTE_W-1:0] TGT_BOTH   = 8'h03;

   localparam logic [RANGE_W-1:0] NO_TARGET_RANGE = 16'd9999;

   typedef enum logic [4:0] {
      HUNT_0   = 5'b00001,
      HUNT_1   = 5'b00010,
      HUNT_2   = 5'b00100,
      HUNT_3   = 5'b01000,
      IN_FRAME = 5'b10000
   } sync_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  tgt_code;
      logic [RANGE_W-1:0] moving_range;
      logic [RANGE_W-1:0] still_range;
   } raw_report_type;

   // packed MSB first, so presence lands in bit 0
   typedef struct packed {
      logic [RANGE_W-1:0] nearest_range_cm;
      logic [RANGE_W-1:0] still_range_cm;
      logic [RANGE_W-1:0] moving_range_cm;
      logic               still_flag;
      logic               moving_flag;
      logic               presence;
   } report_type;

endpackage

`default_nettype wire

FILE: src/rrfp_parser.sv
// Sync header hunt, frame byte counter and field capture with a pending report register.
`default_nettype none

module rrfp_parser #(
   parameter int unsigned FRAME_BYTES = 23
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              in_valid,
   output logic                             in_ready,
   input  wire  [rrfp_pkg::BYTE_W-1:0]      in_byte,
   output logic                             raw_valid,
   input  wire                              raw_ready,
   output rrfp_pkg::raw_report_type         raw_report
);

   localparam int unsigned LAST_POS_I = FRAME_BYTES - 1;
   localparam logic [rrfp_pkg::POS_W-1:0] LAST_POS = LAST_POS_I[rrfp_pkg::POS_W-1:0];

   rrfp_pkg::sync_state_type       state_ff, state_in;
   logic [rrfp_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [rrfp_pkg::BYTE_W-1:0]    tgt_ff, tgt_in;
   logic [rrfp_pkg::RANGE_W-1:0]   moving_ff, moving_in;
   logic [rrfp_pkg::RANGE_W-1:0]   still_ff, still_in;
   logic                           pend_valid_ff, pend_valid_in;
   rrfp_pkg::raw_report_type       pend_ff, pend_in;
   logic                           accept;
   logic                           emit;
   logic                           restart_hit;

   assign in_ready    = !pend_valid_ff || raw_ready;
   assign accept      = in_valid && in_ready;
   assign restart_hit = (in_byte == rrfp_pkg::SYNC_0);
   assign raw_valid   = pend_valid_ff;
   assign raw_report  = pend_ff;

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      tgt_in    = tgt_ff;
      moving_in = moving_ff;
      still_in  = still_ff;
      emit      = 1'b0;
      if (accept) begin
         case (state_ff)
            rrfp_pkg::HUNT_0: begin
               state_in = restart_hit ? rrfp_pkg::HUNT_1 : rrfp_pkg::HUNT_0;
            end
            rrfp_pkg::HUNT_1: begin
               if (in_byte == rrfp_pkg::SYNC_1) begin
                  state_in = rrfp_pkg::HUNT_2;
               end else begin
                  state_in = restart_hit ? rrfp_pkg::HUNT_1 : rrfp_pkg::HUNT_0;
               end
            end
            rrfp_pkg::HUNT_2: begin
               if (in_byte == rrfp_pkg::SYNC_2) begin
                  state_in = rrfp_pkg::HUNT_3;
               end else begin
                  state_in = restart_hit ? rrfp_pkg::HUNT_1 : rrfp_pkg::HUNT_0;
               end
            end
            rrfp_pkg::HUNT_3: begin
               if (in_byte == rrfp_pkg::SYNC_3) begin
                  state_in = rrfp_pkg::IN_FRAME;
                  pos_in   = rrfp_pkg::POS_AFTER_SYNC;
               end else begin
                  state_in = restart_hit ? rrfp_pkg::HUNT_1 : rrfp_pkg::HUNT_0;
               end
            end
            rrfp_pkg::IN_FRAME: begin
               case (pos_ff)
                  rrfp_pkg::OFS_STATE:     tgt_in = in_byte;
                  rrfp_pkg::OFS_MOVING_LO: moving_in = {moving_ff[15:8], in_byte};
                  rrfp_pkg::OFS_MOVING_HI: moving_in = {in_byte, moving_ff[7:0]};
                  rrfp_pkg::OFS_STILL_LO:  still_in = {still_ff[15:8], in_byte};
                  rrfp_pkg::OFS_STILL_HI:  still_in = {in_byte, still_ff[7:0]};
                  default: ;
               endcase
               if (pos_ff >= LAST_POS) begin
                  emit     = 1'b1;
                  state_in = rrfp_pkg::HUNT_0;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            default: begin
               state_in = rrfp_pkg::HUNT_0;
               pos_in   = '0;
            end
         endcase
      end
   end

   always_comb begin
      pend_in.tgt_code     = tgt_in;
      pend_in.moving_range = moving_in;
      pend_in.still_range  = still_in;
      if (emit) begin
         pend_valid_in = 1'b1;
      end else if (raw_ready) begin
         pend_valid_in = 1'b0;
      end else begin
         pend_valid_in = pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rrfp_pkg::HUNT_0;
         pos_ff        <= '0;
         tgt_ff        <= '0;
         moving_ff     <= '0;
         still_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         tgt_ff        <= tgt_in;
         moving_ff     <= moving_in;
         still_ff      <= still_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pend_ff <= pend_in;
      end
   end

`ifndef SYNTHESIS
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff == rrfp_pkg::IN_FRAME |->
         pos_ff >= rrfp_pkg::POS_AFTER_SYNC && pos_ff <= LAST_POS)
      else $error("frame position out of range");

   a_pend_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(pend_valid_ff) |-> $past(accept))
      else $error("report appeared without an accepted byte");

   a_no_report_while_hunting: assert property (@(posedge clock) disable iff (reset)
      accept && state_ff != rrfp_pkg::IN_FRAME |=> !$rose(pend_valid_ff))
      else $error("report raised from a hunting byte");
`endif

endmodule

`default_nettype wire

FILE: src/rrfp_report.sv
// Target flag decode, nearest range select and the result register.
`default_nettype none

module rrfp_report (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          raw_valid,
   output logic                         raw_ready,
   input  rrfp_pkg::raw_report_type     raw_report,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output rrfp_pkg::report_type         rsp_report
);

   logic                     rsp_valid_ff, rsp_valid_in;
   rrfp_pkg::report_type     rsp_ff, rsp_in;
   logic                     mov;
   logic                     stil;
   logic                     load;

   assign raw_ready  = !rsp_valid_ff || rsp_ready;
   assign load       = raw_valid && raw_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_report = rsp_ff;

   always_comb begin
      mov  = (raw_report.tgt_code == rrfp_pkg::TGT_MOVING) ||
             (raw_report.tgt_code == rrfp_pkg::TGT_BOTH);
      stil = (raw_report.tgt_code == rrfp_pkg::TGT_STILL) ||
             (raw_report.tgt_code == rrfp_pkg::TGT_BOTH);
      rsp_in.presence        = (raw_report.tgt_code != '0);
      rsp_in.moving_flag     = mov;
      rsp_in.still_flag      = stil;
      rsp_in.moving_range_cm = raw_report.moving_range;
      rsp_in.still_range_cm  = raw_report.still_range;
      if (mov && stil) begin
         rsp_in.nearest_range_cm = (raw_report.moving_range < raw_report.still_range) ?
                                   raw_report.moving_range : raw_report.still_range;
      end else if (mov) begin
         rsp_in.nearest_range_cm = raw_report.moving_range;
      end else if (stil) begin
         rsp_in.nearest_range_cm = raw_report.still_range;
      end else begin
         rsp_in.nearest_range_cm = rrfp_pkg::NO_TARGET_RANGE;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_no_flag_default: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.moving_flag && !rsp_ff.still_flag |->
         rsp_ff.nearest_range_cm == rrfp_pkg::NO_TARGET_RANGE)
      else $error("nearest range not defaulted");

   a_both_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.moving_flag && rsp_ff.still_flag |->
         rsp_ff.nearest_range_cm <= rsp_ff.moving_range_cm &&
         rsp_ff.nearest_range_cm <= rsp_ff.still_range_cm)
      else $error("nearest range is not the minimum");

   a_flag_implies_presence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.moving_flag || rsp_ff.still_flag) |-> rsp_ff.presence)
      else $error("flag set without presence");
`endif

endmodule

`default_nettype wire

FILE: src/radar_report_frame_parser.sv
// Top level of the radar report frame parser: byte stream in, one report per frame out.
//
//   channel | dir | ports                          | carries
//   req     | in  | req_tvalid/req_tready/req_tdata | one received byte
//   rsp     | out | rsp_tvalid/rsp_tready/rsp_tdata | one report per complete frame
//
// One byte is taken per cycle while req_tready is high. Parser state updates on the
// accepted byte; a finished report passes the pending report register and then the
// result register, which form a two-deep stage, so req_tready only drops while both
// hold reports and rsp_tready is low.
// Synchronous reset returns to hunting for the sync header and clears captured fields.
`default_nettype none

module radar_report_frame_parser #(
   parameter int unsigned FRAME_BYTES = 23
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [rrfp_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [7:0] rx_byte
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // [0] presence, [1] moving_flag, [2] still_flag, [18:3] moving_range_cm,
   // [34:19] still_range_cm, [50:35] nearest_range_cm, [55:51] zero
   output logic [rrfp_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   logic                       raw_valid;
   logic                       raw_ready;
   rrfp_pkg::raw_report_type   raw_report;
   rrfp_pkg::report_type       rsp_report;

   rrfp_parser #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata[rrfp_pkg::BYTE_W-1:0]),
      .raw_valid  (raw_valid),
      .raw_ready  (raw_ready),
      .raw_report (raw_report)
   );

   rrfp_report u_report (
      .clock      (clock),
      .reset      (reset),
      .raw_valid  (raw_valid),
      .raw_ready  (raw_ready),
      .raw_report (raw_report),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_report (rsp_report)
   );

   assign rsp_tdata = {{(rrfp_pkg::RSP_TDATA_W - rrfp_pkg::RSP_FIELDS_W){1'b0}}, rsp_report};

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the radar report frame parser: sync hunting, field capture, backpressure.
module testbench;

   localparam int unsigned FRAME_LEN    = 23;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned RANDOM_BYTES = 600;
   localparam int unsigned PRINT_LIMIT  = 40;
   localparam logic [31:0] SYNC_WORD    = {rrfp_pkg::SYNC_3, rrfp_pkg::SYNC_2,
                                           rrfp_pkg::SYNC_1, rrfp_pkg::SYNC_0};

   typedef enum int {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_mode_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [rrfp_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [rrfp_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // parser shadow state
   int unsigned                  hunt_count;
   logic [rrfp_pkg::POS_W-1:0]   frame_pos;
   logic [rrfp_pkg::BYTE_W-1:0]  target_byte;
   logic [rrfp_pkg::RANGE_W-1:0] moving_cm;
   logic [rrfp_pkg::RANGE_W-1:0] still_cm;

   rrfp_pkg::report_type  pending_reports[$];
   rrfp_pkg::report_type  got_report;
   rrfp_pkg::report_type  want_report;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned burst_left  = 0;
   int unsigned hold_left   = 0;
   int unsigned mode_left   = 0;
   rx_mode_type rx_mode     = RX_OPEN;

   radar_report_frame_parser #(
      .FRAME_BYTES(FRAME_LEN)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // advance the shadow parser by one byte; returns 1 when a report is due
   function automatic bit parse_byte(input logic [rrfp_pkg::BYTE_W-1:0] b,
                                     output rrfp_pkg::report_type rpt);
      bit mov;
      bit stl;
      rpt = '0;
      if (hunt_count < 4) begin
         if (b == SYNC_WORD[8*hunt_count +: 8]) begin
            hunt_count++;
            if (hunt_count == 4) frame_pos = rrfp_pkg::POS_AFTER_SYNC;
         end else begin
            hunt_count = (b == rrfp_pkg::SYNC_0) ? 1 : 0;
         end
         return 1'b0;
      end
      if (frame_pos == rrfp_pkg::OFS_STATE) target_byte = b;
      else if (frame_pos == rrfp_pkg::OFS_MOVING_LO) moving_cm[7:0] = b;
      else if (frame_pos == rrfp_pkg::OFS_MOVING_HI) moving_cm[15:8] = b;
      else if (frame_pos == rrfp_pkg::OFS_STILL_LO) still_cm[7:0] = b;
      else if (frame_pos == rrfp_pkg::OFS_STILL_HI) still_cm[15:8] = b;
      if (int'(frame_pos) + 1 >= FRAME_LEN || frame_pos == 6'd63) begin
         mov = (target_byte == rrfp_pkg::TGT_MOVING) || (target_byte == rrfp_pkg::TGT_BOTH);
         stl = (target_byte == rrfp_pkg::TGT_STILL) || (target_byte == rrfp_pkg::TGT_BOTH);
         rpt.presence         = (target_byte != 8'd0);
         rpt.moving_flag      = mov;
         rpt.still_flag       = stl;
         rpt.moving_range_cm  = moving_cm;
         rpt.still_range_cm   = still_cm;
         rpt.nearest_range_cm = rrfp_pkg::NO_TARGET_RANGE;
         if (mov && stl) rpt.nearest_range_cm = (moving_cm < still_cm) ? moving_cm : still_cm;
         else if (mov) rpt.nearest_range_cm = moving_cm;
         else if (stl) rpt.nearest_range_cm = still_cm;
         hunt_count = 0;
         frame_pos  = '0;
         return 1'b1;
      end
      frame_pos = frame_pos + 1'b1;
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
   endtask

   // called at a falling edge; returns at the falling edge after the request is taken
   task automatic send_byte(input logic [rrfp_pkg::BYTE_W-1:0] b);
      int unsigned          gap;
      rrfp_pkg::report_type rpt;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (parse_byte(b, rpt)) pending_reports.push_back(rpt);
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_header();
      for (int i = 0; i < 4; i++) send_byte(SYNC_WORD[8*i +: 8]);
   endtask

   task automatic send_body(input logic [rrfp_pkg::BYTE_W-1:0] tgt,
                            input logic [rrfp_pkg::RANGE_W-1:0] mov,
                            input logic [rrfp_pkg::RANGE_W-1:0] stl, input bit sync_fill);
      logic [rrfp_pkg::BYTE_W-1:0] b;
      for (int p = rrfp_pkg::POS_AFTER_SYNC; p < FRAME_LEN; p++) begin
         if (p == rrfp_pkg::OFS_STATE) b = tgt;
         else if (p == rrfp_pkg::OFS_MOVING_LO) b = mov[7:0];
         else if (p == rrfp_pkg::OFS_MOVING_HI) b = mov[15:8];
         else if (p == rrfp_pkg::OFS_STILL_LO) b = stl[7:0];
         else if (p == rrfp_pkg::OFS_STILL_HI) b = stl[15:8];
         else if (sync_fill) b = SYNC_WORD[8*(p % 4) +: 8];
         else b = 8'($urandom);
         send_byte(b);
      end
   endtask

   task automatic send_frame(input logic [rrfp_pkg::BYTE_W-1:0] tgt,
                             input logic [rrfp_pkg::RANGE_W-1:0] mov,
                             input logic [rrfp_pkg::RANGE_W-1:0] stl, input bit sync_fill);
      send_header();
      send_body(tgt, mov, stl, sync_fill);
   endtask

   function automatic logic [rrfp_pkg::RANGE_W-1:0] pick_range();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return rrfp_pkg::NO_TARGET_RANGE;
         3: return rrfp_pkg::NO_TARGET_RANGE + 1'b1;
         default: return r[rrfp_pkg::RANGE_W-1:0];
      endcase
   endfunction

   task automatic test_frame_fields();
      send_frame(8'd0, 16'h0000, 16'h0000, 1'b0);
      send_frame(rrfp_pkg::TGT_MOVING, 16'hFFFF, 16'h0000, 1'b0);
      send_frame(rrfp_pkg::TGT_STILL, 16'h0000, 16'hFFFF, 1'b0);
      send_frame(rrfp_pkg::TGT_BOTH, 16'd100, 16'd200, 1'b0);
      send_frame(rrfp_pkg::TGT_BOTH, 16'd200, 16'd100, 1'b0);
      send_frame(rrfp_pkg::TGT_BOTH, 16'hFFFF, 16'hFFFF, 1'b0);
      send_frame(8'd4, 16'h1234, 16'h5678, 1'b0);
      send_frame(8'hFF, 16'hA5A5, 16'h5A5A, 1'b0);
   endtask

   task automatic test_header_resync();
      send_byte(8'h00);
      send_byte(rrfp_pkg::SYNC_0);
      send_frame(rrfp_pkg::TGT_MOVING, 16'd50, 16'd60, 1'b0);
      send_byte(rrfp_pkg::SYNC_0);
      send_byte(rrfp_pkg::SYNC_1);
      send_frame(rrfp_pkg::TGT_STILL, 16'd70, 16'd80, 1'b0);
      send_byte(rrfp_pkg::SYNC_0);
      send_byte(rrfp_pkg::SYNC_1);
      send_byte(rrfp_pkg::SYNC_2);
      send_byte(8'h00);
      send_frame(rrfp_pkg::TGT_BOTH, 16'd90, 16'd30, 1'b0);
      send_byte(rrfp_pkg::SYNC_3);
      send_byte(rrfp_pkg::SYNC_2);
      send_frame(rrfp_pkg::TGT_MOVING, 16'd1, 16'd2, 1'b0);
   endtask

   task automatic test_sync_in_frame();
      send_frame(rrfp_pkg::TGT_BOTH, {rrfp_pkg::SYNC_1, rrfp_pkg::SYNC_0},
                 {rrfp_pkg::SYNC_3, rrfp_pkg::SYNC_2}, 1'b1);
      send_frame(rrfp_pkg::SYNC_0, 16'd5, 16'd6, 1'b1);
   endtask

   task automatic test_input_stall();
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      @(negedge clock);
      burst_left = FRAME_LEN * 6;
      for (int i = 0; i < 6; i++) send_frame(rrfp_pkg::TGT_BOTH, pick_range(), pick_range(), 1'b0);
   endtask

   task automatic test_random_stream();
      int unsigned                 sent;
      int unsigned                 k;
      logic [rrfp_pkg::BYTE_W-1:0] tgt;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            1: begin
               k = $urandom_range(1, 3);
               for (int i = 0; i < k; i++) send_byte(SYNC_WORD[8*i +: 8]);
               send_byte($urandom_range(0, 1) ? rrfp_pkg::SYNC_0 : 8'($urandom));
            end
            default: begin
               tgt = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
               send_frame(tgt, pick_range(), pick_range(), $urandom_range(0, 7) == 0);
               sent += FRAME_LEN;
            end
         endcase
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (rx_mode)
            RX_OPEN:   rsp_tready = 1'b1;
            RX_CHOPPY: rsp_tready = $urandom_range(0, 1);
            default:   rsp_tready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_report = rrfp_pkg::report_type'(rsp_tdata[rrfp_pkg::RSP_FIELDS_W-1:0]);
         if (pending_reports.size() == 0) begin
            report_mismatch("unexpected report, presence", got_report.presence, 0);
         end else begin
            want_report = pending_reports.pop_front();
            if (got_report.presence !== want_report.presence)
               report_mismatch("presence", got_report.presence, want_report.presence);
            if (got_report.moving_flag !== want_report.moving_flag)
               report_mismatch("moving_flag", got_report.moving_flag, want_report.moving_flag);
            if (got_report.still_flag !== want_report.still_flag)
               report_mismatch("still_flag", got_report.still_flag, want_report.still_flag);
            if (got_report.moving_range_cm !== want_report.moving_range_cm)
               report_mismatch("moving_range_cm", got_report.moving_range_cm,
                               want_report.moving_range_cm);
            if (got_report.still_range_cm !== want_report.still_range_cm)
               report_mismatch("still_range_cm", got_report.still_range_cm,
                               want_report.still_range_cm);
            if (got_report.nearest_range_cm !== want_report.nearest_range_cm)
               report_mismatch("nearest_range_cm", got_report.nearest_range_cm,
                               want_report.nearest_range_cm);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      hunt_count  = 0;
      frame_pos   = '0;
      target_byte = '0;
      moving_cm   = '0;
      still_cm    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_frame_fields();
      test_header_resync();
      test_sync_in_frame();
      test_input_stall();
      test_random_stream();
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/rrfp_pkg.sv
src/rrfp_parser.sv
src/rrfp_report.sv
src/radar_report_frame_parser.sv
verif/testbench.sv
